// ----- src/qte_pkg.sv -----
// shared types, constants and the cordic angle table for the quaternion to euler block
`default_nettype none
package qte_pkg;

  // component and datapath widths
  localparam int QW   = 16;  // quaternion component
  localparam int PRW  = 32;  // signed 16x16 product
  localparam int VW   = 36;  // cordic vector, holds 2(ab+cd) with gain and headroom
  localparam int AW   = 26;  // angle accumulator, 2^-16 degree
  localparam int OW   = 16;  // angle result
  localparam int MW   = 30;  // magnitude of sine of pitch below one
  localparam int SQW  = 31;  // root of the pitch cosine, up to 2^30
  localparam int RADW = 62;  // radicand and remainder of the square root

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_LEN         = 24;
  localparam int DEG90_OUT        = 11520;
  localparam int DEG180_OUT       = 23040;
  localparam int RND_HALF         = 256;
  localparam int RND_SHIFT        = 9;

  typedef logic signed [VW-1:0] vec_t;
  typedef logic signed [AW-1:0] acc_t;

  // pitch sideband: sine of pitch at or beyond one in magnitude
  typedef struct packed {
    logic clamp;
    logic neg;
  } pflag_t;

  localparam vec_t ONE_Q30   = vec_t'(64'h0000_0000_4000_0000);
  localparam acc_t DEG90_ACC = acc_t'(90 * 65536);

  // atan(2^-i) in units of 2^-16 degree
  function automatic acc_t atan_step(input int i);
    case (i)
      0:  return acc_t'(2949120);
      1:  return acc_t'(1740967);
      2:  return acc_t'(919879);
      3:  return acc_t'(466945);
      4:  return acc_t'(234379);
      5:  return acc_t'(117304);
      6:  return acc_t'(58666);
      7:  return acc_t'(29335);
      8:  return acc_t'(14668);
      9:  return acc_t'(7334);
      10: return acc_t'(3667);
      11: return acc_t'(1833);
      12: return acc_t'(917);
      13: return acc_t'(458);
      14: return acc_t'(229);
      15: return acc_t'(115);
      16: return acc_t'(57);
      17: return acc_t'(29);
      18: return acc_t'(14);
      19: return acc_t'(7);
      20: return acc_t'(4);
      21: return acc_t'(2);
      22: return acc_t'(1);
      default: return acc_t'(0);
    endcase
  endfunction

  // cordic pipeline depth: pre-rotation, iterations, rounding
  function automatic int cordic_lat(input int steps);
    return ((steps < ATAN_LEN) ? steps : ATAN_LEN) + 2;
  endfunction

endpackage
`default_nettype wire

// ----- src/qte_delay.sv -----
// payload delay line of fixed depth
`default_nettype none
module qte_delay #(
  parameter int W     = 8,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);
  logic [W-1:0] tap [DEPTH];

  // shift one place per cycle
  always_ff @(posedge clk) begin
    tap[0] <= d;
    for (int i = 1; i < DEPTH; i++) begin
      tap[i] <= tap[i-1];
    end
  end

  assign q = tap[DEPTH-1];
endmodule
`default_nettype wire

// ----- src/qte_front.sv -----
// products, trig terms and the pitch cosine radicand
`default_nettype none
module qte_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     vld_in,
  input  logic signed [15:0]       quat_w,
  input  logic signed [15:0]       quat_x,
  input  logic signed [15:0]       quat_y,
  input  logic signed [15:0]       quat_z,
  output logic                     vld2,
  output qte_pkg::vec_t            siny,
  output qte_pkg::vec_t            cosy,
  output qte_pkg::vec_t            sinr,
  output qte_pkg::vec_t            cosr,
  output logic                     vld5,
  output logic [qte_pkg::RADW-1:0] rad,
  output qte_pkg::vec_t            sinp5,
  output qte_pkg::pflag_t          flg5
);
  import qte_pkg::*;

  logic                  vld1, vld3, vld4;
  logic signed [PRW-1:0] p_wy, p_zx, p_wz, p_xy, p_yy, p_zz, p_wx, p_yz, p_xx;
  vec_t                  sinp2, sinp3, sinp4;
  pflag_t                flg3, flg4;
  logic [MW-1:0]         mag3;
  logic [2*MW-1:0]       sq4;
  vec_t                  sinp_abs;

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
      vld3 <= 1'b0;
      vld4 <= 1'b0;
      vld5 <= 1'b0;
    end else begin
      vld1 <= vld_in;
      vld2 <= vld1;
      vld3 <= vld2;
      vld4 <= vld3;
      vld5 <= vld4;
    end
  end

  // stage 1: the nine exact products
  always_ff @(posedge clk) begin
    p_wy <= quat_w * quat_y;
    p_zx <= quat_z * quat_x;
    p_wz <= quat_w * quat_z;
    p_xy <= quat_x * quat_y;
    p_yy <= quat_y * quat_y;
    p_zz <= quat_z * quat_z;
    p_wx <= quat_w * quat_x;
    p_yz <= quat_y * quat_z;
    p_xx <= quat_x * quat_x;
  end

  // stage 2: sine and cosine terms in q30
  always_ff @(posedge clk) begin
    sinp2 <= (vec_t'(p_wy) - vec_t'(p_zx)) <<< 1;
    siny  <= (vec_t'(p_wz) + vec_t'(p_xy)) <<< 1;
    cosy  <= ONE_Q30 - ((vec_t'(p_yy) + vec_t'(p_zz)) <<< 1);
    sinr  <= (vec_t'(p_wx) + vec_t'(p_yz)) <<< 1;
    cosr  <= ONE_Q30 - ((vec_t'(p_xx) + vec_t'(p_yy)) <<< 1);
  end

  assign sinp_abs = sinp2[VW-1] ? -sinp2 : sinp2;

  // stage 3: limit check and magnitude of the pitch sine
  always_ff @(posedge clk) begin
    flg3.clamp <= (sinp2 >= ONE_Q30) || (sinp2 <= -ONE_Q30);
    flg3.neg   <= sinp2[VW-1];
    mag3       <= ((sinp2 >= ONE_Q30) || (sinp2 <= -ONE_Q30)) ? '0 : sinp_abs[MW-1:0];
    sinp3      <= sinp2;
  end

  // stage 4: square of the sine
  always_ff @(posedge clk) begin
    sq4   <= mag3 * mag3;
    flg4  <= flg3;
    sinp4 <= sinp3;
  end

  // stage 5: one minus the square
  always_ff @(posedge clk) begin
    rad   <= (RADW'(1) << 60) - RADW'(sq4);
    flg5  <= flg4;
    sinp5 <= sinp4;
  end
endmodule
`default_nettype wire

// ----- src/qte_isqrt.sv -----
// pipelined floor square root, one root bit per stage
`default_nettype none
module qte_isqrt (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     vld_in,
  input  logic [qte_pkg::RADW-1:0] rad,
  output logic                     vld_out,
  output logic [qte_pkg::SQW-1:0]  root
);
  import qte_pkg::*;

  logic [RADW-1:0] rem [SQW+1];
  logic [SQW-1:0]  rt  [SQW+1];
  logic            vl  [SQW+1];

  assign rem[0] = rad;
  assign rt[0]  = '0;
  assign vl[0]  = vld_in;

  for (genvar s = 0; s < SQW; s++) begin : g_stage
    localparam int K = SQW - 1 - s;
    logic [RADW-1:0] trial;

    // (r + 2^k)^2 - r^2
    assign trial = (RADW'(rt[s]) << (K + 1)) + (RADW'(1) << (2 * K));

    always_ff @(posedge clk) begin
      if (rst) begin
        vl[s+1] <= 1'b0;
      end else begin
        vl[s+1] <= vl[s];
      end
    end

    // try the next root bit
    always_ff @(posedge clk) begin
      if (rem[s] >= trial) begin
        rem[s+1] <= rem[s] - trial;
        rt[s+1]  <= rt[s] | (SQW'(1) << K);
      end else begin
        rem[s+1] <= rem[s];
        rt[s+1]  <= rt[s];
      end
    end
  end

  assign vld_out = vl[SQW];
  assign root    = rt[SQW];
endmodule
`default_nettype wire

// ----- src/qte_cordic.sv -----
// pipelined vectoring cordic, atan2 in 1/128 degree with rounding and limits
`default_nettype none
module qte_cordic #(
  parameter int STEPS = qte_pkg::CORDIC_STEPS_DEF,
  parameter int LIM   = qte_pkg::DEG180_OUT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           vld_in,
  input  qte_pkg::vec_t                  y_in,
  input  qte_pkg::vec_t                  x_in,
  output logic                           vld_out,
  output logic signed [qte_pkg::OW-1:0]  angle
);
  import qte_pkg::*;

  localparam int NIT = (STEPS < ATAN_LEN) ? STEPS : ATAN_LEN;

  vec_t xs  [NIT+1];
  vec_t ys  [NIT+1];
  acc_t acc [NIT+1];
  logic zr  [NIT+1];
  logic vl  [NIT+1];
  acc_t rnd;

  // pre-rotation into the right half plane
  always_ff @(posedge clk) begin
    if (rst) begin
      vl[0] <= 1'b0;
    end else begin
      vl[0] <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    zr[0] <= (x_in == '0) && (y_in == '0);
    if (x_in[VW-1]) begin
      if (!y_in[VW-1]) begin
        xs[0]  <= y_in;
        ys[0]  <= -x_in;
        acc[0] <= DEG90_ACC;
      end else begin
        xs[0]  <= -y_in;
        ys[0]  <= x_in;
        acc[0] <= -DEG90_ACC;
      end
    end else begin
      xs[0]  <= x_in;
      ys[0]  <= y_in;
      acc[0] <= '0;
    end
  end

  for (genvar i = 0; i < NIT; i++) begin : g_iter
    always_ff @(posedge clk) begin
      if (rst) begin
        vl[i+1] <= 1'b0;
      end else begin
        vl[i+1] <= vl[i];
      end
    end

    // micro-rotation towards the x axis
    always_ff @(posedge clk) begin
      zr[i+1] <= zr[i];
      if (ys[i] > 0) begin
        xs[i+1]  <= xs[i] + (ys[i] >>> i);
        ys[i+1]  <= ys[i] - (xs[i] >>> i);
        acc[i+1] <= acc[i] + atan_step(i);
      end else begin
        xs[i+1]  <= xs[i] - (ys[i] >>> i);
        ys[i+1]  <= ys[i] + (xs[i] >>> i);
        acc[i+1] <= acc[i] - atan_step(i);
      end
    end
  end

  assign rnd = (acc[NIT] + acc_t'(RND_HALF)) >>> RND_SHIFT;

  // round half up, limit, zero vector gives zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_out <= 1'b0;
    end else begin
      vld_out <= vl[NIT];
    end
    if (zr[NIT]) begin
      angle <= '0;
    end else if (rnd > acc_t'(LIM)) begin
      angle <= OW'(LIM);
    end else if (rnd < -acc_t'(LIM)) begin
      angle <= OW'(-LIM);
    end else begin
      angle <= rnd[OW-1:0];
    end
  end
endmodule
`default_nettype wire

// ----- src/quaternion_to_euler_degrees.sv -----
// top level: quaternion to roll, pitch and yaw in 1/128 degree
//
//   channel   ports                                          transfer
//   input     start, busy, quat_w/x/y/z                      start high, busy low
//   result    done, roll_angle, pitch_angle, yaw_angle,      done high for one cycle
//             pitch_clamped
//
// one quaternion per cycle; the longest path runs through the 31 stage square root for
// the pitch cosine followed by the pitch cordic
// busy stays low: the pipeline never stops, each result shows for one cycle only
// synchronous reset clears all valid bits; payload registers are not reset
`default_nettype none
module quaternion_to_euler_degrees #(
  parameter int CORDIC_STEPS = qte_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] quat_w,
  input  logic signed [15:0] quat_x,
  input  logic signed [15:0] quat_y,
  input  logic signed [15:0] quat_z,
  output logic               done,
  output logic signed [15:0] roll_angle,
  output logic signed [14:0] pitch_angle,
  output logic signed [15:0] yaw_angle,
  output logic               pitch_clamped
);
  import qte_pkg::*;

  localparam int CLAT   = cordic_lat(CORDIC_STEPS);
  localparam int RY_DLY = 3 + SQW;
  localparam int FL_DLY = SQW + CLAT;
  localparam int LAT    = 37 + CLAT;

  logic              vld2, vld5, sq_vld, p_vld, y_vld, r_vld;
  vec_t              siny, cosy, sinr, cosr, sinp5, sinp_d;
  logic [RADW-1:0]   rad;
  pflag_t            flg5, flg_d;
  logic [SQW-1:0]    root;
  logic signed [OW-1:0] yang, rang, pang, yaw_d, roll_d;

  assign busy = 1'b0;

  // products and trig terms
  qte_front u_front (
    .clk    (clk),
    .rst    (rst),
    .vld_in (start && !busy),
    .quat_w (quat_w),
    .quat_x (quat_x),
    .quat_y (quat_y),
    .quat_z (quat_z),
    .vld2   (vld2),
    .siny   (siny),
    .cosy   (cosy),
    .sinr   (sinr),
    .cosr   (cosr),
    .vld5   (vld5),
    .rad    (rad),
    .sinp5  (sinp5),
    .flg5   (flg5)
  );

  // yaw and roll run early and wait for pitch
  qte_cordic #(.STEPS(CORDIC_STEPS), .LIM(DEG180_OUT)) u_yaw (
    .clk     (clk),
    .rst     (rst),
    .vld_in  (vld2),
    .y_in    (siny),
    .x_in    (cosy),
    .vld_out (y_vld),
    .angle   (yang)
  );

  qte_cordic #(.STEPS(CORDIC_STEPS), .LIM(DEG180_OUT)) u_roll (
    .clk     (clk),
    .rst     (rst),
    .vld_in  (vld2),
    .y_in    (sinr),
    .x_in    (cosr),
    .vld_out (r_vld),
    .angle   (rang)
  );

  qte_delay #(.W(OW), .DEPTH(RY_DLY)) u_yaw_dly (
    .clk (clk),
    .d   (yang),
    .q   (yaw_d)
  );

  qte_delay #(.W(OW), .DEPTH(RY_DLY)) u_roll_dly (
    .clk (clk),
    .d   (rang),
    .q   (roll_d)
  );

  // pitch: cosine by square root, then atan2
  qte_isqrt u_isqrt (
    .clk     (clk),
    .rst     (rst),
    .vld_in  (vld5),
    .rad     (rad),
    .vld_out (sq_vld),
    .root    (root)
  );

  qte_delay #(.W(VW), .DEPTH(SQW)) u_sinp_dly (
    .clk (clk),
    .d   (sinp5),
    .q   (sinp_d)
  );

  qte_delay #(.W($bits(pflag_t)), .DEPTH(FL_DLY)) u_flag_dly (
    .clk (clk),
    .d   (flg5),
    .q   (flg_d)
  );

  qte_cordic #(.STEPS(CORDIC_STEPS), .LIM(DEG90_OUT)) u_pitch (
    .clk     (clk),
    .rst     (rst),
    .vld_in  (sq_vld),
    .y_in    (sinp_d),
    .x_in    (vec_t'(root)),
    .vld_out (p_vld),
    .angle   (pang)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= p_vld;
    end
    roll_angle    <= roll_d;
    yaw_angle     <= yaw_d;
    pitch_clamped <= flg_d.clamp;
    if (flg_d.clamp) begin
      pitch_angle <= flg_d.neg ? 15'(-DEG90_OUT) : 15'(DEG90_OUT);
    end else begin
      pitch_angle <= pang[14:0];
    end
  end

`ifndef SYNTH
  // every result comes from an accepted quaternion a fixed latency earlier
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result without matching transfer");

  // yaw and roll finish a fixed distance ahead of pitch
  a_align: assert property (@(posedge clk) disable iff (rst)
    p_vld |-> $past(y_vld && r_vld, RY_DLY))
    else $error("yaw or roll out of step with pitch");

  // a clamped pitch is exactly plus or minus ninety degrees
  a_clamp: assert property (@(posedge clk) disable iff (rst)
    (done && pitch_clamped) |-> (pitch_angle == 15'sd11520 || pitch_angle == -15'sd11520))
    else $error("clamped pitch not at ninety degrees");

  // roll and yaw stay within half a turn
  a_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (roll_angle <= 16'sd23040 && roll_angle >= -16'sd23040 &&
              yaw_angle <= 16'sd23040 && yaw_angle >= -16'sd23040))
    else $error("roll or yaw out of range");
`endif

endmodule
`default_nettype wire
